>>> sv/jhsp_pkg.sv
// ---------------------------------------------------------------------------
// jhsp_pkg
// shared types, codes and helpers of the jpeg header size parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jhsp_pkg;

  // parse phases; IDLE means a result went out and bytes are dropped
  typedef enum logic [3:0] {
    PH_SOI0   = 4'd0,
    PH_SOI1   = 4'd1,
    PH_PREFIX = 4'd2,
    PH_MARKER = 4'd3,
    PH_LENHI  = 4'd4,
    PH_LENLO  = 4'd5,
    PH_SKIP   = 4'd6,
    PH_SOF    = 4'd7,
    PH_IDLE   = 4'd8
  } phase_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SOI    = 2'd1;
  localparam logic [1:0] ST_NO_PREFIX = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // pixel format codes
  localparam logic [1:0] FMT_YUV444  = 2'd0;
  localparam logic [1:0] FMT_YUV420  = 2'd1;
  localparam logic [1:0] FMT_YUV422  = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  // stream byte values
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_SOI  = 8'hD8;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] SAMP_11   = 8'h11;
  localparam logic [7:0] SAMP_22   = 8'h22;
  localparam logic [7:0] COMP_Y    = 8'h01;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [1:0]  status;
  } result_t;

  // round up to a multiple of 8, wrapping at 16 bits
  function automatic logic [15:0] round8(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd7;
    return {s[15:3], 3'b000};
  endfunction

  // round up to a multiple of 16, wrapping at 16 bits
  function automatic logic [15:0] round16(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd15;
    return {s[15:4], 4'b0000};
  endfunction

endpackage

>>> sv/jpeg_header_size_parser_unit.sv
// ---------------------------------------------------------------------------
// jpeg_header_size_parser_unit
// byte-serial jpeg header walker that reports sof0 image size and format
// ---------------------------------------------------------------------------
// channel | dir | tdata                            | side
// in      | in  | [7:0] data_byte                  | tlast = last_byte
// out     | out | [1:0] status, [17:2] width,      | none
//         |     | [33:18] height, [35:34] format   |
//
// one byte is taken per cycle while in_tready is high; its decode is a single
// step of compare and counter logic between walker state and result buffer
// a result appears on out_tvalid the cycle after the byte that decides it,
// or later while an earlier result still waits in the output register
// in_tready drops only while both result buffer entries are full
// rst_n is synchronous; it clears the walker and empties the buffer
// after a result the remaining bytes of the file are consumed silently,
// and the final byte re-arms the walker for a new start marker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_header_size_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] data_byte
  input  logic                                in_tlast,  // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [17:2] image_width, [33:18] image_height,
  // [35:34] pixel_format, [39:36] zero
  output logic [jhsp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic              acc;
  logic              res_valid;
  jhsp_pkg::result_t res;
  jhsp_pkg::result_t out_res;
  logic              space;

  // item accepted this cycle
  assign acc       = in_tvalid && in_tready;
  assign in_tready = space;

  jhsp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (acc),
    .byte_i      (in_tdata),
    .last_i      (in_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  jhsp_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (res_valid),
    .push_data_i  (res),
    .space_o      (space),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_data_o   (out_res)
  );

  // pad the packed result up to whole bytes
  assign out_tdata = {{(jhsp_pkg::OUT_TDATA_W - $bits(jhsp_pkg::result_t)){1'b0}}, out_res};

endmodule

>>> sv/jhsp_parse.sv
// ---------------------------------------------------------------------------
// jhsp_parse
// per-byte segment walker: state registers plus one step of decode logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jhsp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             res_valid_o,
  output jhsp_pkg::result_t res_o
);

  jhsp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [1:0]  pos_mod3_r, pos_mod3_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] held_w_r, held_w_nxt;
  logic [15:0] held_h_r, held_h_nxt;
  logic [7:0]  marker_r, marker_nxt;

  logic        hit;
  logic [15:0] len_full;
  logic [16:0] pos_plus1;
  logic        comp_pos;
  logic        scan_end;
  logic        sof_short;
  logic        sof_nocomp;

  assign len_full   = {seg_len_r[15:8], byte_i};
  assign pos_plus1  = {1'b0, pos_r} + 17'd1;
  assign comp_pos   = (pos_r >= 16'd8) && (pos_mod3_r == 2'd2);
  assign scan_end   = ({1'b0, pos_r} + 17'd3) >= {1'b0, seg_len_r};
  assign sof_short  = !pend_r && (pos_r == 16'd6) && (seg_len_r <= 16'd8);
  assign sof_nocomp = !pend_r && comp_pos && (byte_i != jhsp_pkg::COMP_Y) && scan_end;

  // result decode
  always_comb begin
    hit                = 1'b0;
    res_o.status       = jhsp_pkg::ST_OK;
    res_o.image_width  = '0;
    res_o.image_height = '0;
    res_o.pixel_format = jhsp_pkg::FMT_UNKNOWN;
    unique case (phase_r)
      jhsp_pkg::PH_SOI0: begin
        if (byte_i != jhsp_pkg::BYTE_FF) begin
          hit          = 1'b1;
          res_o.status = jhsp_pkg::ST_NO_SOI;
        end
      end
      jhsp_pkg::PH_SOI1: begin
        if (byte_i != jhsp_pkg::BYTE_SOI) begin
          hit          = 1'b1;
          res_o.status = jhsp_pkg::ST_NO_SOI;
        end
      end
      jhsp_pkg::PH_PREFIX: begin
        if (byte_i != jhsp_pkg::BYTE_FF) begin
          hit          = 1'b1;
          res_o.status = jhsp_pkg::ST_NO_PREFIX;
        end
      end
      jhsp_pkg::PH_LENLO: begin
        if (marker_r != jhsp_pkg::BYTE_SOF0 && len_full < 16'd2) begin
          hit          = 1'b1;
          res_o.status = jhsp_pkg::ST_NO_PREFIX;
        end
      end
      jhsp_pkg::PH_SOF: begin
        if (pend_r) begin
          hit = 1'b1;
          if (byte_i == jhsp_pkg::SAMP_11) begin
            res_o.image_width  = jhsp_pkg::round8(held_w_r);
            res_o.image_height = jhsp_pkg::round8(held_h_r);
            res_o.pixel_format = jhsp_pkg::FMT_YUV444;
          end else if (byte_i == jhsp_pkg::SAMP_22) begin
            res_o.image_width  = jhsp_pkg::round16(held_w_r);
            res_o.image_height = jhsp_pkg::round16(held_h_r);
            res_o.pixel_format = jhsp_pkg::FMT_YUV420;
          end else begin
            res_o.image_width  = jhsp_pkg::round16(held_w_r);
            res_o.image_height = jhsp_pkg::round8(held_h_r);
            res_o.pixel_format = jhsp_pkg::FMT_YUV422;
          end
        end else if (sof_short) begin
          // header too short for component entries: width just completed
          hit                = 1'b1;
          res_o.image_width  = {held_w_r[7:0], byte_i};
          res_o.image_height = held_h_r;
        end else if (sof_nocomp) begin
          hit                = 1'b1;
          res_o.image_width  = held_w_r;
          res_o.image_height = held_h_r;
        end
      end
      default: ;
    endcase
    // final byte with nothing decided
    if (!hit && last_i && phase_r != jhsp_pkg::PH_IDLE) begin
      hit                = 1'b1;
      res_o.status       = jhsp_pkg::ST_TRUNC;
      res_o.image_width  = '0;
      res_o.image_height = '0;
      res_o.pixel_format = jhsp_pkg::FMT_UNKNOWN;
    end
  end

  assign res_valid_o = acc_i && hit;

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    seg_len_nxt  = seg_len_r;
    pos_nxt      = pos_r;
    pos_mod3_nxt = pos_mod3_r;
    pend_nxt     = pend_r;
    held_w_nxt   = held_w_r;
    held_h_nxt   = held_h_r;
    marker_nxt   = marker_r;
    unique case (phase_r)
      jhsp_pkg::PH_SOI0:   phase_nxt = jhsp_pkg::PH_SOI1;
      jhsp_pkg::PH_SOI1:   phase_nxt = jhsp_pkg::PH_PREFIX;
      jhsp_pkg::PH_PREFIX: phase_nxt = jhsp_pkg::PH_MARKER;
      jhsp_pkg::PH_MARKER: begin
        // fill bytes keep us here
        if (byte_i != jhsp_pkg::BYTE_FF) begin
          marker_nxt = byte_i;
          phase_nxt  = jhsp_pkg::PH_LENHI;
        end
      end
      jhsp_pkg::PH_LENHI: begin
        seg_len_nxt = {byte_i, 8'h00};
        phase_nxt   = jhsp_pkg::PH_LENLO;
      end
      jhsp_pkg::PH_LENLO: begin
        seg_len_nxt  = len_full;
        pos_nxt      = 16'd2;
        pos_mod3_nxt = 2'd2;
        pend_nxt     = 1'b0;
        if (marker_r == jhsp_pkg::BYTE_SOF0) phase_nxt = jhsp_pkg::PH_SOF;
        else if (len_full == 16'd2)           phase_nxt = jhsp_pkg::PH_PREFIX;
        else                                  phase_nxt = jhsp_pkg::PH_SKIP;
      end
      jhsp_pkg::PH_SKIP: begin
        pos_nxt = pos_plus1[15:0];
        if (pos_plus1 >= {1'b0, seg_len_r}) phase_nxt = jhsp_pkg::PH_PREFIX;
      end
      jhsp_pkg::PH_SOF: begin
        if (!pend_r) begin
          if (pos_r == 16'd3 || pos_r == 16'd4)
            held_h_nxt = {held_h_r[7:0], byte_i};
          else if (pos_r == 16'd5 || pos_r == 16'd6)
            held_w_nxt = {held_w_r[7:0], byte_i};
          else if (comp_pos && byte_i == jhsp_pkg::COMP_Y)
            pend_nxt = 1'b1;
          pos_nxt      = pos_plus1[15:0];
          pos_mod3_nxt = (pos_mod3_r == 2'd2) ? 2'd0 : pos_mod3_r + 2'd1;
        end
      end
      default: ;
    endcase
    if (hit) phase_nxt = jhsp_pkg::PH_IDLE;
    // end of file re-arms everything
    if (last_i) begin
      phase_nxt    = jhsp_pkg::PH_SOI0;
      seg_len_nxt  = '0;
      pos_nxt      = '0;
      pos_mod3_nxt = '0;
      pend_nxt     = 1'b0;
      held_w_nxt   = '0;
      held_h_nxt   = '0;
      marker_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jhsp_pkg::PH_SOI0;
      seg_len_r  <= '0;
      pos_r      <= '0;
      pos_mod3_r <= '0;
      pend_r     <= 1'b0;
      held_w_r   <= '0;
      held_h_r   <= '0;
      marker_r   <= '0;
    end else if (acc_i) begin
      phase_r    <= phase_nxt;
      seg_len_r  <= seg_len_nxt;
      pos_r      <= pos_nxt;
      pos_mod3_r <= pos_mod3_nxt;
      pend_r     <= pend_nxt;
      held_w_r   <= held_w_nxt;
      held_h_r   <= held_h_nxt;
      marker_r   <= marker_nxt;
    end
  end

  // a decided item parks the walker until the final byte
  a_idle_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && hit && !last_i) |=> (phase_r == jhsp_pkg::PH_IDLE))
    else $error("walker did not park after a result");

  // nothing comes out of the idle phase but the final-byte re-arm
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == jhsp_pkg::PH_IDLE) |-> !hit)
    else $error("result raised while parked");

  // the final byte always brings the walker back to the start marker
  a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && last_i) |=> (phase_r == jhsp_pkg::PH_SOI0))
    else $error("walker not re-armed after the final byte");

endmodule

>>> sv/jhsp_out_buf.sv
// ---------------------------------------------------------------------------
// jhsp_out_buf
// two-entry result buffer: output register plus skid entry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jhsp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid_i,
  input  jhsp_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jhsp_pkg::result_t out_data_o
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  jhsp_pkg::result_t main_r, main_nxt;
  jhsp_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign pop         = main_valid_r && out_ready_i;
  assign space_o     = !skid_valid_r;
  assign out_valid_o = main_valid_r;
  assign out_data_o  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_valid_i) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data_i;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data_i;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid_i && skid_valid_r))
    else $error("item pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (main_valid_r && main_r == $past(skid_r)))
    else $error("skid entry lost on drain");

endmodule
